/* rtl/core/lru_pkg.sv */
// shared constants and codes for the lru replacement list
package lru_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VICTIM = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

/* rtl/core/lru_replacer_top.sv */
// top level of the lru replacement list
// Tracks up to ENTRIES distinct keys in insertion order in a single-port-write,
// registered-read key store. Every transfer gives exactly one result. A request
// is handled by one sequencer that walks the store one slot per cycle: a search
// walk over the tracked keys, then, if a key is removed, a shift walk that moves
// every later key down by one slot, then an append for an insert and a result
// cycle. A key that is not found makes the search walk cover every tracked key;
// a request on an empty store or with the unused action code 3 skips both walks.
// The input stalls from the transfer until the result is placed in the output
// register, which holds it until it is taken; a result still waiting there holds
// the sequencer in its result cycle. Only the low KEY_BITS bits of a key are
// stored and compared.
module lru_replacer_top
    import lru_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_W-1:0]    o_victim_key,
    output logic [OCC_W-1:0]    o_occupancy
);

    localparam int STORE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IDX_W   = $clog2(ENTRIES);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [STORE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [STORE_W-1:0] mem_rdata;
    logic [STORE_W-1:0] victim;

    lru_ctrl #(
        .ENTRIES (ENTRIES),
        .STORE_W (STORE_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_key       (i_key[STORE_W-1:0]),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_victim    (victim),
        .o_occupancy (o_occupancy),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    lru_store #(
        .ENTRIES (ENTRIES),
        .STORE_W (STORE_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_victim_key = KEY_W'(victim);

endmodule

/* rtl/core/lru_store.sv */
// key store memory, one write port and one registered read port
module lru_store
    import lru_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int STORE_W   = KEY_BITS_DEF,
    localparam int IDX_W    = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  logic [STORE_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]   i_raddr,
    output logic [STORE_W-1:0] o_rdata
);

    logic [STORE_W-1:0] r_mem [ENTRIES];
    logic [STORE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lru_ctrl.sv */
// request sequencer: search walk, shift walk, append and result register
module lru_ctrl
    import lru_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int STORE_W   = KEY_BITS_DEF,
    localparam int IDX_W    = $clog2(ENTRIES),
    localparam int CNT_W    = $clog2(ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [STORE_W-1:0]  i_key,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [STORE_W-1:0]  o_victim,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_we,
    output logic [IDX_W-1:0]    o_waddr,
    output logic [STORE_W-1:0]  o_wdata,
    output logic [IDX_W-1:0]    o_raddr,
    input  logic [STORE_W-1:0]  i_rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

    logic [2:0]          r_state,   n_state;
    logic [ACTION_W-1:0] r_action,  n_action;
    logic [STORE_W-1:0]  r_key,     n_key;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_idx,     n_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                r_found,   n_found;
    logic [STATUS_W-1:0] r_status,  n_status;
    logic [STORE_W-1:0]  r_victim,  n_victim;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [STORE_W-1:0]  r_out_victim, n_out_victim;
    logic [OCC_W-1:0]    r_out_occ, n_out_occ;

    logic             in_xfer;
    logic             out_xfer;
    logic             more;
    logic             hit;
    logic [CNT_W-1:0] shift_dst;
    logic [CNT_W-1:0] cnt_left;

    assign in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign out_xfer  = r_out_valid && !i_out_stall;
    assign more      = r_idx < r_count;
    assign hit       = r_cmp_vld && ((i_rdata == r_key) || (r_action == ACT_VICTIM));
    assign shift_dst = r_cmp_idx - ONE;
    assign cnt_left  = r_count - CNT_W'(r_found);

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_key        = r_key;
        n_count      = r_count;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_found      = r_found;
        n_status     = r_status;
        n_victim     = r_victim;
        n_out_valid  = r_out_valid && !out_xfer;
        n_out_status = r_out_status;
        n_out_victim = r_out_victim;
        n_out_occ    = r_out_occ;
        o_we         = 1'b0;
        o_waddr      = shift_dst[IDX_W-1:0];
        o_wdata      = i_rdata;
        o_raddr      = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_action  = i_action;
                    n_key     = i_key;
                    n_found   = 1'b0;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_victim  = '0;
                    if ((i_action == ACT_INSERT || i_action == ACT_VICTIM ||
                         i_action == ACT_ERASE) && r_count != '0) begin
                        n_state = S_FIND;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIND: begin
                n_cmp_vld = more;
                n_cmp_idx = r_idx;
                if (more) begin
                    n_idx = r_idx + ONE;
                end
                if (hit) begin
                    n_found   = 1'b1;
                    n_victim  = (r_action == ACT_VICTIM) ? i_rdata : '0;
                    n_idx     = r_cmp_idx + ONE;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SHIFT;
                end else if (r_cmp_vld && r_cmp_idx == r_count - ONE) begin
                    n_state = S_FIN;
                end
            end
            S_SHIFT: begin
                n_cmp_vld = more;
                n_cmp_idx = r_idx;
                if (more) begin
                    n_idx = r_idx + ONE;
                end
                // move each later key one slot towards the old end
                o_we = r_cmp_vld;
                if (!more && !r_cmp_vld) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_count  = cnt_left;
                n_status = ST_OK;
                case (r_action)
                    ACT_INSERT: begin
                        if (cnt_left >= CNT_MAX) begin
                            n_status = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = cnt_left[IDX_W-1:0];
                            o_wdata = r_key;
                            n_count = cnt_left + ONE;
                        end
                    end
                    ACT_VICTIM: begin
                        if (!r_found) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    ACT_ERASE: begin
                        if (!r_found) begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || out_xfer) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_victim = r_victim;
                    n_out_occ    = OCC_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_status     <= n_status;
        r_victim     <= n_victim;
        r_out_status <= n_out_status;
        r_out_victim <= n_out_victim;
        r_out_occ    <= n_out_occ;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_victim    = r_out_victim;
    assign o_occupancy = r_out_occ;

endmodule

/* rtl/core/lru_chk.sv */
// port checker for the lru replacement list and its bind
module lru_chk
    import lru_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [KEY_W-1:0]    o_victim_key,
    input logic [OCC_W-1:0]    o_occupancy
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_victim_key) && $stable(o_occupancy))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a request is in work");

    // a victim key only comes with a successful request
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_victim_key == '0)
        else $error("victim key on a failed request");

    // occupancy never exceeds the store size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (ENTRIES > 31) || (int'(o_occupancy) <= ENTRIES))
        else $error("occupancy above store size");

    // a full status only after a store that was full
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> (ENTRIES > 31) ||
        (int'(o_occupancy) == ENTRIES))
        else $error("full reported below store size");

endmodule

bind lru_replacer_top lru_chk #(.ENTRIES(ENTRIES)) u_chk (.*);
